// File: src/pthc_pkg.sv
// ============================================================================
// pthc_pkg: shared types and constants for the PTH compensation block
// Calibration bundle, queue item layout, register indexes and the fixed
// constants of the integer compensation formulas.
// ============================================================================
package pthc_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIXED_CAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL     = 3'd4;

  // Formula constants.
  localparam logic signed [32:0] P_TF_OFS  = 33'sd128000;
  localparam logic [20:0]        P_BASE    = 21'd1048576;
  localparam logic signed [16:0] P_SCALE   = 17'sd3125;
  localparam logic [63:0]        P_G_OFS   = 64'h0000_8000_0000_0000;
  localparam logic [31:0]        H_OFS     = 32'd76800;
  localparam logic [31:0]        H_MAX     = 32'd419430400;
  localparam logic [31:0]        H_RND     = 32'd16384;
  localparam logic [31:0]        H_Z_OFS   = 32'd2097152;
  localparam logic [31:0]        H_B_RND   = 32'd8192;
  localparam logic [31:0]        H_Y_OFS   = 32'd32768;
  localparam logic [31:0]        T_RND     = 32'd128;

  // Calibration words as written through the configuration port.
  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [47:0] mixed_cal;
    logic [39:0] hum_cal;
  } cal_t;

  // One sample handed from the front end to the back end.
  typedef struct packed {
    logic [31:0]        t_fine;
    logic signed [15:0] temp_centi;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
  } samp_t;

  // Data that rides along with the divider pipeline.
  typedef struct packed {
    logic               qneg;
    logic               ok;
    logic signed [15:0] temp_centi;
    logic [16:0]        hum;
  } div_side_t;

  // Low partial of a 64-bit by 17-bit signed product, modulo 2^64.
  function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] pr;
    pr = $signed({1'b0, a[31:0]}) * b;
    return {{14{pr[49]}}, pr};
  endfunction

  // High partial of the same product; the sum of both is the product mod 2^64.
  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic signed [16:0] b);
    logic [31:0] bx;
    logic [31:0] pr;
    bx = {{15{b[16]}}, b};
    pr = a[63:32] * bx;
    return {pr, 32'd0};
  endfunction

endpackage

// File: src/pthc_front.sv
// ============================================================================
// pthc_front: temperature front end
// Accepts raw samples, computes the fine temperature and the saturated
// centidegree value in a four-stage pipeline and hands them to the queue.
// ============================================================================
module pthc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  pthc_pkg::cal_t      cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [23:0]         in_raw_temp,
  input  logic [23:0]         in_raw_press,
  input  logic [15:0]         in_raw_hum,
  output logic                q_valid,
  input  logic                q_ready,
  output pthc_pkg::samp_t     q_data
);
  import pthc_pkg::*;

  logic [15:0] t1;
  logic [31:0] t2, t3;
  logic [19:0] adc_t;

  logic [3:0]  vld_r, vld_nxt;
  logic        adv;

  logic [31:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [19:0] ap1_r, ap2_r, ap3_r, ap4_r;
  logic [15:0] ah1_r, ah2_r, ah3_r, ah4_r;
  logic [31:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic [31:0] va_r, va_nxt, m3_r, m3_nxt, m2_sh;
  logic [31:0] tf_r, tf_nxt, vb;
  logic [31:0] tc5, tc;
  logic signed [15:0] tc_sat;

  // Calibration fields.
  always_comb begin
    t1    = cal.temp_cal[15:0];
    t2    = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
    t3    = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
    adc_t = in_raw_temp[23:4];
  end

  // Pipeline advances unless the last stage holds a transaction the queue refuses.
  assign adv      = !vld_r[3] || q_ready;
  assign in_ready = adv;
  assign q_valid  = vld_r[3];
  assign vld_nxt  = {vld_r[2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage arithmetic, 32-bit wrapping.
  always_comb begin
    d1_nxt = {15'd0, adc_t[19:3]} - {15'd0, t1, 1'b0};
    d2_nxt = {16'd0, adc_t[19:4]} - {16'd0, t1};
    m1_nxt = d1_r * t2;
    m2_nxt = d2_r * d2_r;
    va_nxt = $signed(m1_r) >>> 11;
    m2_sh  = $signed(m2_r) >>> 12;
    m3_nxt = m2_sh * t3;
    vb     = $signed(m3_r) >>> 14;
    tf_nxt = va_r + vb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
      ap1_r <= in_raw_press[23:4];
      ah1_r <= in_raw_hum;
      m1_r  <= m1_nxt;
      m2_r  <= m2_nxt;
      ap2_r <= ap1_r;
      ah2_r <= ah1_r;
      va_r  <= va_nxt;
      m3_r  <= m3_nxt;
      ap3_r <= ap2_r;
      ah3_r <= ah2_r;
      tf_r  <= tf_nxt;
      ap4_r <= ap3_r;
      ah4_r <= ah3_r;
    end
  end

  // Centidegrees from the fine temperature, saturated to 16 bits.
  always_comb begin
    tc5 = {tf_r[29:0], 2'b00} + tf_r + T_RND;
    tc  = $signed(tc5) >>> 8;
    if (tc[31]) begin
      tc_sat = (tc < 32'hFFFF_8000) ? 16'sh8000 : tc[15:0];
    end else begin
      tc_sat = (tc > 32'h0000_7FFF) ? 16'sh7FFF : tc[15:0];
    end
    q_data.t_fine     = tf_r;
    q_data.temp_centi = tc_sat;
    q_data.adc_p      = ap4_r;
    q_data.adc_h      = ah4_r;
  end

endmodule

// File: src/pthc_queue.sv
// ============================================================================
// pthc_queue: two-entry queue between front and back end
// Lets either side stall without at once stopping the other.
// ============================================================================
module pthc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  pthc_pkg::samp_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output pthc_pkg::samp_t rd_data
);
  import pthc_pkg::*;

  samp_t       mem_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic        push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/pthc_back.sv
// ============================================================================
// pthc_back: pressure and humidity back end
// Nine setup stages, a 64-stage restoring divider, six finishing stages and
// an output register, all advancing together under output backpressure.
// ============================================================================
module pthc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pthc_pkg::cal_t     cal,
  input  logic               in_valid,
  output logic               in_ready,
  input  pthc_pkg::samp_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]        out_press_q8,
  output logic               out_press_ok,
  output logic [16:0]        out_hum_q10
);
  import pthc_pkg::*;

  localparam int unsigned PRE_STG = 9;
  localparam int unsigned DIV_STG = 64;
  localparam int unsigned NSTG    = PRE_STG + DIV_STG + 6;

  // Calibration fields.
  logic signed [16:0] p1, p2, p3, p5, p6, p8, p9;
  logic [63:0]        p4_sh, p7_sh;
  logic [31:0]        h1, h2, h3, h4_sh, h5, h6;

  always_comb begin
    p1    = {1'b0, cal.press_cal_a[15:0]};
    p2    = {cal.press_cal_a[31], cal.press_cal_a[31:16]};
    p3    = {cal.press_cal_a[47], cal.press_cal_a[47:32]};
    p4_sh = {{13{cal.press_cal_a[63]}}, cal.press_cal_a[63:48], 35'd0};
    p5    = {cal.press_cal_b[15], cal.press_cal_b[15:0]};
    p6    = {cal.press_cal_b[31], cal.press_cal_b[31:16]};
    p7_sh = {{44{cal.press_cal_b[47]}}, cal.press_cal_b[47:32], 4'd0};
    p8    = {cal.press_cal_b[63], cal.press_cal_b[63:48]};
    p9    = {cal.mixed_cal[15], cal.mixed_cal[15:0]};
    h1    = {24'd0, cal.mixed_cal[23:16]};
    h2    = {{16{cal.mixed_cal[39]}}, cal.mixed_cal[39:24]};
    h3    = {24'd0, cal.mixed_cal[47:40]};
    h4_sh = {cal.hum_cal[11:0], 20'd0};
    h5    = {{16{cal.hum_cal[31]}}, cal.hum_cal[31:16]};
    h6    = {{24{cal.hum_cal[39]}}, cal.hum_cal[39:32]};
  end

  // Shared stall control.
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic            out_valid_r;
  logic            adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign vld_nxt   = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // Setup stage registers.
  logic signed [32:0] b1_w1_r, b1_w1_nxt;
  logic [31:0]        b1_hv_r, b1_hv_nxt;
  logic [20:0]        b1_pin_r, b2_pin_r, b3_pin_r, b4_pin_r, b5_pin_r;
  logic [20:0]        b1_pin_nxt;
  logic [15:0]        b1_ah_r, b2_ah_r;
  logic signed [15:0] b1_tc_r, b2_tc_r, b3_tc_r, b4_tc_r, b5_tc_r, b6_tc_r, b7_tc_r, b8_tc_r;

  logic signed [65:0] a_full;
  logic [63:0]        b2_a_r, b2_a_nxt;
  logic signed [49:0] b2_w1p5_r, b2_w1p5_nxt, b2_w1p2_r, b2_w1p2_nxt;
  logic [31:0]        b2_mh5_r, b2_mh5_nxt, b2_mh6_r, b2_mh6_nxt, b2_mh3_r, b2_mh3_nxt;

  logic [63:0]        b3_blo_r, b3_blo_nxt, b3_bhi_r, b3_bhi_nxt;
  logic [63:0]        b3_elo_r, b3_elo_nxt, b3_ehi_r, b3_ehi_nxt;
  logic [63:0]        b3_c_r, b3_c_nxt, b3_f_r, b3_f_nxt;
  logic [31:0]        ha_pre;
  logic [31:0]        b3_ha_r, b3_ha_nxt, b3_hx_r, b3_hx_nxt, b3_hy_r, b3_hy_nxt;

  logic [63:0]        b4_bs_r, b4_bs_nxt, b4_cd_r, b4_cd_nxt, b4_es_r, b4_es_nxt, b4_f_r;
  logic [31:0]        b4_ha_r, b4_hxy_r, b4_hxy_nxt;

  logic [63:0]        b5_w2_r, b5_w2_nxt, b5_w1b_r, b5_w1b_nxt, e_sh;
  logic [31:0]        b5_ha_r, b5_hzh_r, b5_hzh_nxt, hz;

  logic [63:0]        g_sum;
  logic [63:0]        b6_glo_r, b6_glo_nxt, b6_ghi_r, b6_ghi_nxt, b6_nd_r, b6_nd_nxt;
  logic [31:0]        hb_pre, hb, b6_hv2_r, b6_hv2_nxt;

  logic [63:0]        b7_g_r, b7_g_nxt, b7_nlo_r, b7_nlo_nxt, b7_nhi_r, b7_nhi_nxt;
  logic [31:0]        hs, b7_hss_r, b7_hss_nxt, b7_hv2_r;

  logic [63:0]        g_sh;
  logic [30:0]        b8_w1c_r, b8_w1c_nxt;
  logic [63:0]        b8_n_r, b8_n_nxt;
  logic [31:0]        ht, b8_hth_r, b8_hth_nxt, b8_hv2_r;

  logic [63:0]        b9_an_r, b9_an_nxt;
  logic [30:0]        b9_ad_r, b9_ad_nxt;
  div_side_t          b9_sd_r, b9_sd_nxt;
  logic [31:0]        hq, hv3, hcl;

  // Setup stage arithmetic.
  always_comb begin
    // Stage 1: offsets.
    b1_w1_nxt  = $signed({in_data.t_fine[31], in_data.t_fine}) - P_TF_OFS;
    b1_hv_nxt  = in_data.t_fine - H_OFS;
    b1_pin_nxt = P_BASE - {1'b0, in_data.adc_p};
    // Stage 2: first products.
    a_full      = b1_w1_r * b1_w1_r;
    b2_a_nxt    = a_full[63:0];
    b2_w1p5_nxt = b1_w1_r * p5;
    b2_w1p2_nxt = b1_w1_r * p2;
    b2_mh5_nxt  = h5 * b1_hv_r;
    b2_mh6_nxt  = b1_hv_r * h6;
    b2_mh3_nxt  = b1_hv_r * h3;
    // Stage 3: partial products modulo 2^64 and humidity terms.
    b3_blo_nxt = mul_lo(b2_a_r, p6);
    b3_bhi_nxt = mul_hi(b2_a_r, p6);
    b3_elo_nxt = mul_lo(b2_a_r, p3);
    b3_ehi_nxt = mul_hi(b2_a_r, p3);
    b3_c_nxt   = {b2_w1p5_r[46:0], 17'd0};
    b3_f_nxt   = {{2{b2_w1p2_r[49]}}, b2_w1p2_r, 12'd0};
    ha_pre     = {2'd0, b2_ah_r, 14'd0} - h4_sh - b2_mh5_r + H_RND;
    b3_ha_nxt  = $signed(ha_pre) >>> 15;
    b3_hx_nxt  = $signed(b2_mh6_r) >>> 10;
    b3_hy_nxt  = $signed(b2_mh3_r) >>> 11;
    b3_hy_nxt  = b3_hy_nxt + H_Y_OFS;
    // Stage 4: partial sums and the humidity product.
    b4_bs_nxt  = b3_blo_r + b3_bhi_r;
    b4_cd_nxt  = b3_c_r + p4_sh;
    b4_es_nxt  = b3_elo_r + b3_ehi_r;
    b4_hxy_nxt = b3_hx_r * b3_hy_r;
    // Stage 5: w2 and the pressure divisor term.
    b5_w2_nxt  = b4_bs_r + b4_cd_r;
    e_sh       = $signed(b4_es_r) >>> 8;
    b5_w1b_nxt = e_sh + b4_f_r;
    hz         = $signed(b4_hxy_r) >>> 10;
    hz         = hz + H_Z_OFS;
    b5_hzh_nxt = hz * h2;
    // Stage 6: scaling by P1 and the dividend difference.
    g_sum      = P_G_OFS + b5_w1b_r;
    b6_glo_nxt = mul_lo(g_sum, p1);
    b6_ghi_nxt = mul_hi(g_sum, p1);
    b6_nd_nxt  = {12'd0, b5_pin_r, 31'd0} - b5_w2_r;
    hb_pre     = b5_hzh_r + H_B_RND;
    hb         = $signed(hb_pre) >>> 14;
    b6_hv2_nxt = b5_ha_r * hb;
    // Stage 7: scaled dividend partials.
    b7_g_nxt   = b6_glo_r + b6_ghi_r;
    b7_nlo_nxt = mul_lo(b6_nd_r, P_SCALE);
    b7_nhi_nxt = mul_hi(b6_nd_r, P_SCALE);
    hs         = $signed(b6_hv2_r) >>> 15;
    b7_hss_nxt = hs * hs;
    // Stage 8: divisor and dividend.
    g_sh       = $signed(b7_g_r) >>> 33;
    b8_w1c_nxt = g_sh[30:0];
    b8_n_nxt   = b7_nlo_r + b7_nhi_r;
    ht         = $signed(b7_hss_r) >>> 7;
    b8_hth_nxt = ht * h1;
    // Stage 9: magnitudes for the divider, humidity clamp.
    b9_an_nxt  = b8_n_r[63] ? (64'd0 - b8_n_r) : b8_n_r;
    b9_ad_nxt  = b8_w1c_r[30] ? (31'd0 - b8_w1c_r) : b8_w1c_r;
    hq         = $signed(b8_hth_r) >>> 4;
    hv3        = b8_hv2_r - hq;
    if (hv3[31]) begin
      hcl = '0;
    end else if (hv3 > H_MAX) begin
      hcl = H_MAX;
    end else begin
      hcl = hv3;
    end
    b9_sd_nxt.qneg       = b8_n_r[63] ^ b8_w1c_r[30];
    b9_sd_nxt.ok         = |b8_w1c_r;
    b9_sd_nxt.temp_centi = b8_tc_r;
    b9_sd_nxt.hum        = hcl[28:12];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_w1_r   <= b1_w1_nxt;
      b1_hv_r   <= b1_hv_nxt;
      b1_pin_r  <= b1_pin_nxt;
      b1_ah_r   <= in_data.adc_h;
      b1_tc_r   <= in_data.temp_centi;
      b2_a_r    <= b2_a_nxt;
      b2_w1p5_r <= b2_w1p5_nxt;
      b2_w1p2_r <= b2_w1p2_nxt;
      b2_mh5_r  <= b2_mh5_nxt;
      b2_mh6_r  <= b2_mh6_nxt;
      b2_mh3_r  <= b2_mh3_nxt;
      b2_pin_r  <= b1_pin_r;
      b2_ah_r   <= b1_ah_r;
      b2_tc_r   <= b1_tc_r;
      b3_blo_r  <= b3_blo_nxt;
      b3_bhi_r  <= b3_bhi_nxt;
      b3_elo_r  <= b3_elo_nxt;
      b3_ehi_r  <= b3_ehi_nxt;
      b3_c_r    <= b3_c_nxt;
      b3_f_r    <= b3_f_nxt;
      b3_ha_r   <= b3_ha_nxt;
      b3_hx_r   <= b3_hx_nxt;
      b3_hy_r   <= b3_hy_nxt;
      b3_pin_r  <= b2_pin_r;
      b3_tc_r   <= b2_tc_r;
      b4_bs_r   <= b4_bs_nxt;
      b4_cd_r   <= b4_cd_nxt;
      b4_es_r   <= b4_es_nxt;
      b4_f_r    <= b3_f_r;
      b4_hxy_r  <= b4_hxy_nxt;
      b4_ha_r   <= b3_ha_r;
      b4_pin_r  <= b3_pin_r;
      b4_tc_r   <= b3_tc_r;
      b5_w2_r   <= b5_w2_nxt;
      b5_w1b_r  <= b5_w1b_nxt;
      b5_hzh_r  <= b5_hzh_nxt;
      b5_ha_r   <= b4_ha_r;
      b5_pin_r  <= b4_pin_r;
      b5_tc_r   <= b4_tc_r;
      b6_glo_r  <= b6_glo_nxt;
      b6_ghi_r  <= b6_ghi_nxt;
      b6_nd_r   <= b6_nd_nxt;
      b6_hv2_r  <= b6_hv2_nxt;
      b6_tc_r   <= b5_tc_r;
      b7_g_r    <= b7_g_nxt;
      b7_nlo_r  <= b7_nlo_nxt;
      b7_nhi_r  <= b7_nhi_nxt;
      b7_hss_r  <= b7_hss_nxt;
      b7_hv2_r  <= b6_hv2_r;
      b7_tc_r   <= b6_tc_r;
      b8_w1c_r  <= b8_w1c_nxt;
      b8_n_r    <= b8_n_nxt;
      b8_hth_r  <= b8_hth_nxt;
      b8_hv2_r  <= b7_hv2_r;
      b8_tc_r   <= b7_tc_r;
      b9_an_r   <= b9_an_nxt;
      b9_ad_r   <= b9_ad_nxt;
      b9_sd_r   <= b9_sd_nxt;
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [30:0] dv_rem_r [DIV_STG];
  logic [63:0] dv_nq_r  [DIV_STG];
  logic [30:0] dv_ad_r  [DIV_STG];
  div_side_t   dv_sd_r  [DIV_STG];

  for (genvar gi = 0; gi < DIV_STG; gi++) begin : g_div
    logic [30:0] rem_in;
    logic [63:0] nq_in;
    logic [30:0] ad_in;
    div_side_t   sd_in;
    logic [31:0] trial, diff;
    logic        ge;

    if (gi == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = b9_an_r;
      assign ad_in  = b9_ad_r;
      assign sd_in  = b9_sd_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[gi-1];
      assign nq_in  = dv_nq_r[gi-1];
      assign ad_in  = dv_ad_r[gi-1];
      assign sd_in  = dv_sd_r[gi-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[63]};
      diff  = trial - {1'b0, ad_in};
      ge    = (trial >= {1'b0, ad_in});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[gi] <= ge ? diff[30:0] : trial[30:0];
        dv_nq_r[gi]  <= {nq_in[62:0], ge};
        dv_ad_r[gi]  <= ad_in;
        dv_sd_r[gi]  <= sd_in;
      end
    end
  end

  // Finishing stages.
  logic [63:0] b10_p_r, b10_p_nxt, b11_p_r, b12_p_r;
  div_side_t   b10_sd_r, b11_sd_r, b12_sd_r, b13_sd_r, b14_sd_r, b15_sd_r;
  logic [63:0] q_sh;
  logic [63:0] b11_sq_r, b11_sq_nxt, b11_x2lo_r, b11_x2lo_nxt, b11_x2hi_r, b11_x2hi_nxt;
  logic [31:0] b11_cr_r, b11_cr_nxt;
  logic [63:0] x2_sum, b12_s_r, b12_s_nxt, b12_x2_r, b12_x2_nxt;
  logic [63:0] b13_slo_r, b13_slo_nxt, b13_shi_r, b13_shi_nxt, b13_sum1_r, b13_sum1_nxt;
  logic [63:0] b14_x1s_r, b14_x1s_nxt, b14_sum1_r;
  logic [63:0] x1, b15_s2_r, b15_s2_nxt;
  logic [63:0] pf;
  logic [31:0] press_nxt;

  always_comb begin
    b10_p_nxt    = dv_sd_r[DIV_STG-1].qneg ? (64'd0 - dv_nq_r[DIV_STG-1])
                                           : dv_nq_r[DIV_STG-1];
    q_sh         = $signed(b10_p_r) >>> 13;
    b11_sq_nxt   = {32'd0, q_sh[31:0]} * {32'd0, q_sh[31:0]};
    b11_cr_nxt   = q_sh[31:0] * q_sh[63:32];
    b11_x2lo_nxt = mul_lo(b10_p_r, p8);
    b11_x2hi_nxt = mul_hi(b10_p_r, p8);
    b12_s_nxt    = b11_sq_r + {b11_cr_r[30:0], 1'b0, 32'd0};
    x2_sum       = b11_x2lo_r + b11_x2hi_r;
    b12_x2_nxt   = $signed(x2_sum) >>> 19;
    b13_slo_nxt  = mul_lo(b12_s_r, p9);
    b13_shi_nxt  = mul_hi(b12_s_r, p9);
    b13_sum1_nxt = b12_p_r + b12_x2_r;
    b14_x1s_nxt  = b13_slo_r + b13_shi_r;
    x1           = $signed(b14_x1s_r) >>> 25;
    b15_s2_nxt   = b14_sum1_r + x1;
    // Final shift, offset and saturation.
    pf           = $signed(b15_s2_r) >>> 8;
    pf           = pf + p7_sh;
    if (!b15_sd_r.ok || pf[63]) begin
      press_nxt = '0;
    end else if (|pf[62:32]) begin
      press_nxt = 32'hFFFF_FFFF;
    end else begin
      press_nxt = pf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b10_p_r    <= b10_p_nxt;
      b10_sd_r   <= dv_sd_r[DIV_STG-1];
      b11_sq_r   <= b11_sq_nxt;
      b11_cr_r   <= b11_cr_nxt;
      b11_x2lo_r <= b11_x2lo_nxt;
      b11_x2hi_r <= b11_x2hi_nxt;
      b11_p_r    <= b10_p_r;
      b11_sd_r   <= b10_sd_r;
      b12_s_r    <= b12_s_nxt;
      b12_x2_r   <= b12_x2_nxt;
      b12_p_r    <= b11_p_r;
      b12_sd_r   <= b11_sd_r;
      b13_slo_r  <= b13_slo_nxt;
      b13_shi_r  <= b13_shi_nxt;
      b13_sum1_r <= b13_sum1_nxt;
      b13_sd_r   <= b12_sd_r;
      b14_x1s_r  <= b14_x1s_nxt;
      b14_sum1_r <= b13_sum1_r;
      b14_sd_r   <= b13_sd_r;
      b15_s2_r   <= b15_s2_nxt;
      b15_sd_r   <= b14_sd_r;
      out_temp_centi <= b15_sd_r.temp_centi;
      out_press_q8   <= press_nxt;
      out_press_ok   <= b15_sd_r.ok;
      out_hum_q10    <= b15_sd_r.hum;
    end
  end

endmodule

// File: src/pth_sensor_compensation.sv
// ============================================================================
// pth_sensor_compensation: integer PTH sensor compensation
// Turns raw temperature, pressure and humidity readings into compensated
// values using the calibration words held in five configuration registers.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_ready     in_raw_temp, in_raw_press, in_raw_hum
//   out_     output     out_valid / out_ready   out_temp_centi, out_press_q8,
//                                               out_press_ok, out_hum_q10
//   cfg_     input      cfg_we                  cfg_idx, cfg_wdata
//
// One transaction is accepted per cycle when the result side keeps up.
// A sample passes four front-end stages, the queue, nine setup stages,
// the 64-stage pressure divider and six finishing stages with the
// output register. Reset (rst_n low, synchronous) empties all pipelines and
// clears the calibration registers. A stalled output holds the back end; the
// two-entry queue lets the front end keep accepting until it fills.
// ============================================================================
module pth_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_raw_temp,
  input  logic [23:0]        in_raw_press,
  input  logic [15:0]        in_raw_hum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]        out_press_q8,
  output logic               out_press_ok,
  output logic [16:0]        out_hum_q10
);
  import pthc_pkg::*;

  cal_t  cal_r;
  samp_t fq_data, qb_data;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;

  // Calibration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TEMP_CAL:    cal_r.temp_cal    <= cfg_wdata[47:0];
        REG_PRESS_CAL_A: cal_r.press_cal_a <= cfg_wdata;
        REG_PRESS_CAL_B: cal_r.press_cal_b <= cfg_wdata;
        REG_MIXED_CAL:   cal_r.mixed_cal   <= cfg_wdata[47:0];
        REG_HUM_CAL:     cal_r.hum_cal     <= cfg_wdata[39:0];
        default: begin
        end
      endcase
    end
  end

  // Temperature front end.
  pthc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cal          (cal_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_raw_temp  (in_raw_temp),
    .in_raw_press (in_raw_press),
    .in_raw_hum   (in_raw_hum),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_data       (fq_data)
  );

  // Decoupling queue.
  pthc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Pressure and humidity back end.
  pthc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cal            (cal_r),
    .in_valid       (qb_valid),
    .in_ready       (qb_ready),
    .in_data        (qb_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_temp_centi (out_temp_centi),
    .out_press_q8   (out_press_q8),
    .out_press_ok   (out_press_ok),
    .out_hum_q10    (out_hum_q10)
  );

endmodule
